// ----- hw/rtl/gffp_pkg.sv -----
package gffp_pkg;

   // Field widths of the request, response and configuration transactions
   localparam int CMD_W  = 1;
   localparam int DIM_W  = 4;
   localparam int POSX_W = 4;
   localparam int POSY_W = 5;
   localparam int GW_W   = 5;

   localparam logic [GW_W-1:0] GW_RESET = 5'd16;

   // Request command codes
   localparam logic [CMD_W-1:0] CMD_PLACE = 1'b0;
   localparam logic [CMD_W-1:0] CMD_CLEAR = 1'b1;

   // Controller to datapath commands
   typedef struct packed {
      logic accept;      // latch the request fields
      logic clear_grid;  // free every cell
      logic start;       // reset row, offset and accumulator for a new search
      logic scan;        // read the next row of the candidate band
      logic eval;        // test the band, advance to the next row if no fit
      logic mark_wr;     // write back one row with the rectangle marked
      logic load_rsp;    // load the response payload
      logic rsp_placed;  // placed flag for the response
   } gffp_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic is_clear;
      logic bad_item;
      logic row_last;
      logic y_last;
      logic fit_found;
   } gffp_sts_type;

endpackage

// ----- hw/rtl/gffp_ram.sv -----
module gffp_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/gffp_ctrl.sv -----
module gffp_ctrl
   import gffp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   input  gffp_sts_type sts,
   output gffp_cmd_type cmd
);

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_CHECK   = 3'd1;
   localparam logic [2:0] ST_SCAN    = 3'd2;
   localparam logic [2:0] ST_EVAL    = 3'd3;
   localparam logic [2:0] ST_MARK_RD = 3'd4;
   localparam logic [2:0] ST_MARK_WR = 3'd5;
   localparam logic [2:0] ST_DONE    = 3'd6;

   logic [2:0] state_ff, state_in;
   logic       ok_ff, ok_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in  = state_ff;
      ok_in     = ok_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_CHECK;
            end
         end
         ST_CHECK: begin
            ok_in = 1'b0;
            if (sts.is_clear) begin
               cmd.clear_grid = 1'b1;
               state_in       = ST_DONE;
            end else if (sts.bad_item) begin
               state_in = ST_DONE;
            end else begin
               cmd.start = 1'b1;
               state_in  = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.row_last) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            cmd.eval = 1'b1;
            if (sts.fit_found) begin
               state_in = ST_MARK_RD;
            end else if (sts.y_last) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_MARK_RD: begin
            state_in = ST_MARK_WR;
         end
         ST_MARK_WR: begin
            cmd.mark_wr = 1'b1;
            if (sts.row_last) begin
               ok_in    = 1'b1;
               state_in = ST_DONE;
            end else begin
               state_in = ST_MARK_RD;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.load_rsp   = 1'b1;
               cmd.rsp_placed = ok_ff;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = cmd.load_rsp | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ok_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ok_ff        <= ok_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_load_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> (!rsp_valid_ff || !rsp_stall))
      else $error("response loaded over a pending transaction");

   a_ok_from_mark: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && ok_ff) |->
         ($past(state_ff) == ST_MARK_WR || $past(state_ff) == ST_DONE))
      else $error("placed result without a mark pass");

   a_rsp_rise_load: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.load_rsp))
      else $error("response valid rose without a load");

endmodule

// ----- hw/rtl/gffp_dp.sv -----
module gffp_dp
   import gffp_pkg::*;
#(
   parameter int GRID_W   = 16,
   parameter int GRID_H   = 32,
   parameter int MAX_ITEM = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [CMD_W-1:0]  req_command,
   input  logic [DIM_W-1:0]  req_item_width,
   input  logic [DIM_W-1:0]  req_item_height,
   input  logic              csr_write_enable,
   input  logic [GW_W-1:0]   csr_write_data,
   input  gffp_cmd_type      cmd,
   output gffp_sts_type      sts,
   output logic              rsp_placed,
   output logic [POSX_W-1:0] rsp_pos_x,
   output logic [POSY_W-1:0] rsp_pos_y
);

   localparam int XW   = (GRID_W > 1) ? $clog2(GRID_W) : 1;
   localparam int YW   = (GRID_H > 1) ? $clog2(GRID_H) : 1;
   localparam int EW   = $clog2(GRID_W + 1);
   localparam int PADW = GRID_W + 16;

   logic [CMD_W-1:0]  cmd_ff;
   logic [DIM_W-1:0]  w_ff, h_ff;
   logic [GW_W-1:0]   gw_ff, gw_in;
   logic [EW-1:0]     ew_ff, ew_in, ew_now;
   logic [YW-1:0]     y_ff, y_in;
   logic [DIM_W-1:0]  r_ff, r_in;
   logic [GRID_W-1:0] acc_ff, acc_in;
   logic [XW-1:0]     x_ff, x_in;
   logic              pend_ff;
   logic              rvalid_ff;
   logic [GRID_H-1:0] row_vld_ff, row_vld_in;
   logic              placed_ff;
   logic [POSX_W-1:0] pos_x_ff;
   logic [POSY_W-1:0] pos_y_ff;

   logic [9:0]        row_sum;
   logic [YW-1:0]     row_addr;
   logic [GRID_W-1:0] ram_rdata, rd_row, comb_row, span, wdata;
   logic [15:0]       wmask;
   logic [GRID_W-1:0] fit;
   logic              found;
   logic [XW-1:0]     fx;
   logic [PADW-1:0]   pad;
   logic [PADW-1:0]   win;
   logic [31:0]       x_ext, y_ext;

   // Band row address: candidate top row plus offset
   assign row_sum  = 10'(y_ff) + 10'(r_ff);
   assign row_addr = row_sum[YW-1:0];

   // Rows never written since the last clear read as free
   assign rd_row   = rvalid_ff ? ram_rdata : '0;
   assign comb_row = acc_ff | rd_row;
   assign wmask    = 16'((17'(1) << w_ff) - 17'(1));

   assign ew_now = (8'(gw_ff) > 8'(GRID_W)) ? EW'(GRID_W) : EW'(gw_ff);

   always_comb begin
      pad = PADW'(comb_row);
      for (int x = 0; x < GRID_W; x++) begin
         win    = pad >> x;
         fit[x] = ((win[15:0] & wmask) == 16'd0) &&
                  ((8'(x) + 8'(w_ff)) <= 8'(ew_ff));
      end
      found = 1'b0;
      fx    = '0;
      for (int x = GRID_W - 1; x >= 0; x--) begin
         if (fit[x]) begin
            found = 1'b1;
            fx    = XW'(x);
         end
      end
   end

   assign span  = GRID_W'(PADW'(wmask) << x_ff);
   assign wdata = rd_row | span;

   assign sts.is_clear  = (cmd_ff == CMD_CLEAR);
   assign sts.bad_item  = (w_ff == '0) || (h_ff == '0) ||
                          (5'(w_ff) > 5'(MAX_ITEM)) || (5'(h_ff) > 5'(MAX_ITEM)) ||
                          (8'(w_ff) > 8'(ew_now)) || (10'(h_ff) > 10'(GRID_H));
   assign sts.row_last  = ((5'(r_ff) + 5'd1) == 5'(h_ff));
   assign sts.y_last    = ((10'(y_ff) + 10'(h_ff)) == 10'(GRID_H));
   assign sts.fit_found = found;

   always_comb begin
      gw_in      = gw_ff;
      ew_in      = ew_ff;
      y_in       = y_ff;
      r_in       = r_ff;
      acc_in     = acc_ff;
      x_in       = x_ff;
      row_vld_in = row_vld_ff;

      if (csr_write_enable) begin
         gw_in = csr_write_data;
      end

      if (pend_ff) begin
         acc_in = comb_row;
      end

      if (cmd.start) begin
         ew_in  = ew_now;
         y_in   = '0;
         r_in   = '0;
         acc_in = '0;
      end

      if (cmd.scan && !sts.row_last) begin
         r_in = r_ff + 4'd1;
      end

      if (cmd.eval) begin
         r_in = '0;
         if (found) begin
            x_in = fx;
         end else begin
            y_in   = y_ff + YW'(1);
            acc_in = '0;
         end
      end

      if (cmd.mark_wr) begin
         r_in                 = r_ff + 4'd1;
         row_vld_in[row_addr] = 1'b1;
      end

      if (cmd.clear_grid) begin
         row_vld_in = '0;
      end
   end

   assign x_ext = 32'(x_ff);
   assign y_ext = 32'(y_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         gw_ff      <= GW_RESET;
         row_vld_ff <= '0;
         pend_ff    <= 1'b0;
      end else begin
         gw_ff      <= gw_in;
         row_vld_ff <= row_vld_in;
         pend_ff    <= cmd.scan;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         cmd_ff <= req_command;
         w_ff   <= req_item_width;
         h_ff   <= req_item_height;
      end
      ew_ff     <= ew_in;
      y_ff      <= y_in;
      r_ff      <= r_in;
      acc_ff    <= acc_in;
      x_ff      <= x_in;
      rvalid_ff <= row_vld_ff[row_addr];
      if (cmd.load_rsp) begin
         placed_ff <= cmd.rsp_placed;
         pos_x_ff  <= cmd.rsp_placed ? x_ext[POSX_W-1:0] : '0;
         pos_y_ff  <= cmd.rsp_placed ? y_ext[POSY_W-1:0] : '0;
      end
   end

   gffp_ram #(
      .WIDTH (GRID_W),
      .DEPTH (GRID_H)
   ) u_occ_ram (
      .clock   (clock),
      .wr_en   (cmd.mark_wr),
      .wr_addr (row_addr),
      .wr_data (wdata),
      .rd_addr (row_addr),
      .rd_data (ram_rdata)
   );

   assign rsp_placed = placed_ff;
   assign rsp_pos_x  = pos_x_ff;
   assign rsp_pos_y  = pos_y_ff;

   a_wr_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.mark_wr |-> (row_sum < 10'(GRID_H)))
      else $error("occupancy write past the last row");

   a_mark_in_width: assert property (@(posedge clock) disable iff (reset)
      cmd.mark_wr |-> ((8'(x_ff) + 8'(w_ff)) <= 8'(ew_ff)))
      else $error("marked span beyond the active width");

   a_fit_is_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.eval && found) |=> ((span & $past(comb_row)) == '0))
      else $error("chosen corner overlaps occupied cells");

endmodule

// ----- hw/rtl/grid_first_fit_rect_placer.sv -----
// Channel   Direction  Handshake            Payload
// req_      in         req_valid/req_stall  req_command, req_item_width, req_item_height
// rsp_      out        rsp_valid/rsp_stall  rsp_placed, rsp_pos_x, rsp_pos_y
// csr_      in         csr_write_enable     csr_write_data (grid_width)
//
// A place transaction tries candidate rows in turn, at most GRID_H-h+1 of them, where h is
// the item height; a clear or a rejected item does no search. The occupancy RAM has a single
// read port: one band row is read per cycle, and marking does a read and a write per row.
// Reset is synchronous; it empties the grid at once through per-row valid bits. A stalled
// response is held in the output register while the next request is taken.
module grid_first_fit_rect_placer
   import gffp_pkg::*;
#(
   parameter int GRID_W   = 16,
   parameter int GRID_H   = 32,
   parameter int MAX_ITEM = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [CMD_W-1:0]  req_command,
   input  logic [DIM_W-1:0]  req_item_width,
   input  logic [DIM_W-1:0]  req_item_height,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_placed,
   output logic [POSX_W-1:0] rsp_pos_x,
   output logic [POSY_W-1:0] rsp_pos_y,
   input  logic              csr_write_enable,
   input  logic [GW_W-1:0]   csr_write_data
);

   // Commands from the sequencer and status back from the datapath
   gffp_cmd_type cmd;
   gffp_sts_type sts;

   // Sequencer: accept a transaction, check it, sweep candidate rows, mark the
   // chosen band, then hand the result to the output register.
   gffp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Datapath: occupancy RAM, band accumulator, parallel fit test with a
   // leftmost-first priority pick, row write-back and the response payload.
   gffp_dp #(
      .GRID_W   (GRID_W),
      .GRID_H   (GRID_H),
      .MAX_ITEM (MAX_ITEM)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_command      (req_command),
      .req_item_width   (req_item_width),
      .req_item_height  (req_item_height),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .cmd              (cmd),
      .sts              (sts),
      .rsp_placed       (rsp_placed),
      .rsp_pos_x        (rsp_pos_x),
      .rsp_pos_y        (rsp_pos_y)
   );

endmodule
